### rtl/ntst_pkg.sv
package ntst_pkg;
  localparam int ValueWidth = 64;
  localparam int CharWidth = 7;
  localparam logic [63:0] DecLimit = 64'd999999999999;
  localparam int DecDigits = 12;
  localparam int BcdWidth = 4 * DecDigits;

  localparam logic [6:0] ChZero = 7'h30;
  localparam logic [6:0] ChOne = 7'h31;
  localparam logic [6:0] ChMinus = 7'h2d;
  localparam logic [6:0] ChPlus = 7'h2b;
  localparam logic [6:0] ChX = 7'h78;
  localparam logic [6:0] ChDot = 7'h2e;
  localparam logic [6:0] ChP = 7'h70;
  localparam logic [6:0] ChSlash = 7'h2f;

  function automatic logic [6:0] hex_char(input logic [3:0] d);
    hex_char = (d < 4'd10) ? (ChZero + {3'd0, d}) : (7'h57 + {3'd0, d});
  endfunction
endpackage

### rtl/ntst_if.sv
interface ntst_in_if;
  logic valid;
  logic ready;
  logic action;
  logic [63:0] value;
  modport source (output valid, action, value, input ready);
  modport sink (input valid, action, value, output ready);
endinterface

interface ntst_out_if;
  logic valid;
  logic ready;
  logic [6:0] out_char;
  logic last_char;
  modport source (output valid, out_char, last_char, input ready);
  modport sink (input valid, out_char, last_char, output ready);
endinterface

### rtl/ntst_dabble.sv
module ntst_dabble
  import ntst_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [39:0] bin,
  output logic done,
  output logic [BcdWidth-1:0] bcd
);
  logic [39:0] sh;
  logic [5:0] cnt;
  logic busy;
  logic [BcdWidth-1:0] adj;

  always_comb begin
    for (int i = 0; i < DecDigits; i++) begin
      adj[4*i +: 4] = (bcd[4*i +: 4] > 4'd4) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      sh <= bin;
      bcd <= '0;
      cnt <= 6'd0;
    end else if (busy) begin
      bcd <= {adj[BcdWidth-2:0], sh[39]};
      sh <= {sh[38:0], 1'b0};
      cnt <= cnt + 6'd1;
      if (cnt == 6'd39) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end
endmodule

### rtl/number_to_source_text_core.sv
// sequence, for every value: input transaction, start, bit-serial binary to bcd shift of the
// 40-bit operand, done and load, then one character per cycle while out_ch.ready is high
// one value at a time: a new value is accepted only after its last character has been taken
// reset: synchronous active-high rst clears control; no item in flight afterwards
module number_to_source_text_core
  import ntst_pkg::*;
(
  input logic clk,
  input logic rst,
  ntst_in_if.sink in_ch,
  ntst_out_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_LOAD = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;
  logic [6:0] buf_q [24];
  logic [4:0] len;
  logic [4:0] pos;
  logic [39:0] conv_in;
  logic conv_start, conv_done;
  logic [BcdWidth-1:0] bcd;
  logic act;
  logic [63:0] val;

  ntst_dabble u_dab (.clk, .rst, .start(conv_start), .bin(conv_in), .done(conv_done), .bcd);

  logic neg_i;
  logic [63:0] mag;
  logic [10:0] bexp;
  logic [51:0] mant, frac;
  logic [5:0] lz;
  logic [11:0] eabs;
  logic eneg;
  logic [3:0] nd;
  logic [3:0] ndig;
  logic [4:0] nhex;

  always_comb begin
    neg_i = val[63] && (val != 64'h8000000000000000);
    mag = neg_i ? (~val + 64'd1) : val;
    bexp = val[62:52];
    mant = val[51:0];
    lz = 6'd0;
    for (int k = 0; k < 52; k++) begin
      if (mant[k]) lz = 6'(51 - k);
    end
    if (bexp != 11'd0) begin
      frac = mant;
      eneg = bexp < 11'd1023;
      eabs = eneg ? 12'(11'd1023 - bexp) : 12'(bexp - 11'd1023);
    end else begin
      frac = mant << (lz + 6'd1);
      eneg = 1'b1;
      eabs = 12'd1023 + 12'(lz);
    end
    nd = 4'd0;
    for (int i = 0; i < 13; i++) begin
      if (frac[48-4*i +: 4] != 4'd0) nd = 4'(i + 1);
    end
    ndig = 4'd1;
    for (int i = 1; i < DecDigits; i++) begin
      if (bcd[4*i +: 4] != 4'd0) ndig = 4'(i + 1);
    end
    nhex = 5'd1;
    for (int i = 1; i < 16; i++) begin
      if (mag[4*i +: 4] != 4'd0) nhex = 5'(i + 1);
    end
  end

  assign conv_in = act ? {28'd0, eabs} : mag[39:0];
  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = (state == S_EMIT);
  assign out_ch.out_char = buf_q[pos];
  assign out_ch.last_char = (pos == len - 5'd1);

  always_ff @(posedge clk) begin
    conv_start <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            act <= in_ch.action;
            val <= in_ch.value;
            state <= S_CONV;
            conv_start <= 1'b1;
          end
        end
        S_CONV: begin
          if (conv_done) state <= S_LOAD;
        end
        S_LOAD: begin
          automatic logic [4:0] n = 5'd0;
          pos <= 5'd0;
          state <= S_EMIT;
          if (!act) begin
            if (val == 64'd0) begin
              buf_q[0] <= ChZero; n = 5'd1;
            end else begin
              if (neg_i) begin buf_q[0] <= ChMinus; n = 5'd1; end
              if (mag <= DecLimit) begin
                for (int i = 0; i < DecDigits; i++) begin
                  if (4'(i) < ndig) buf_q[5'(n + 5'(ndig) - 5'd1 - 5'(i))] <=
                    ChZero + {3'd0, bcd[4*i +: 4]};
                end
                n = n + 5'(ndig);
              end else begin
                buf_q[n] <= ChZero; buf_q[n + 5'd1] <= ChX; n = n + 5'd2;
                for (int i = 0; i < 16; i++) begin
                  if (5'(i) < nhex) buf_q[5'(n + nhex - 5'd1 - 5'(i))] <=
                    hex_char(mag[4*i +: 4]);
                end
                n = n + nhex;
              end
            end
          end else if (bexp == 11'h7ff) begin
            if (mant != 52'd0) begin
              buf_q[0] <= ChZero; buf_q[1] <= ChSlash; buf_q[2] <= ChZero; n = 5'd3;
            end else begin
              if (val[63]) begin buf_q[0] <= ChMinus; n = 5'd1; end
              buf_q[n] <= ChOne; buf_q[n + 5'd1] <= ChSlash; buf_q[n + 5'd2] <= ChZero;
              n = n + 5'd3;
            end
          end else if (bexp == 11'd0 && mant == 52'd0) begin
            buf_q[0] <= ChZero; n = 5'd1;
          end else begin
            if (val[63]) begin buf_q[0] <= ChMinus; n = 5'd1; end
            buf_q[n] <= ChZero; buf_q[n + 5'd1] <= ChX; buf_q[n + 5'd2] <= ChOne;
            n = n + 5'd3;
            if (nd != 4'd0) begin
              buf_q[n] <= ChDot; n = n + 5'd1;
              for (int i = 0; i < 13; i++) begin
                if (4'(i) < nd) buf_q[5'(n + 5'(i))] <= hex_char(frac[48-4*i +: 4]);
              end
              n = n + 5'(nd);
            end
            buf_q[n] <= ChP; buf_q[n + 5'd1] <= eneg ? ChMinus : ChPlus; n = n + 5'd2;
            for (int i = 0; i < 4; i++) begin
              if (4'(i) < ndig) buf_q[5'(n + 5'(ndig) - 5'd1 - 5'(i))] <=
                ChZero + {3'd0, bcd[4*i +: 4]};
            end
            n = n + 5'(ndig);
          end
          len <= n;
        end
        S_EMIT: begin
          if (out_ch.ready) begin
            if (pos == len - 5'd1) state <= S_IDLE;
            else pos <= pos + 5'd1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

### rtl/ntst_checker.sv
module ntst_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic last_char
);
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input taken while emitting");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("valid dropped");
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && last_char |=> !out_valid) else $error("emit after last");
  a_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready after accept");
endmodule

bind number_to_source_text_core ntst_checker u_chk (
  .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .last_char(out_ch.last_char)
);
